// ----- design/twoa_pkg.sv -----
`timescale 1ns / 1ps
package twoa_pkg;

  localparam int NUM_CPUS_DEF    = 8;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DIV_STEPS       = 64;
  localparam logic [30:0] AVG_MAX = 31'h7fff_ffff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAP,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    CLS_RUN    = 2'd0,
    CLS_BIG    = 2'd1,
    CLS_IOWAIT = 2'd2
  } cls_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  cpu_index;
    logic [15:0] count_delta;
    logic        is_increment;
    logic [63:0] timestamp;
    logic [15:0] big_count;
    logic [15:0] iowait_count;
  } in_item_t;

  typedef struct packed {
    logic        is_query_result;
    logic [30:0] run_avg;
    logic [30:0] big_avg;
    logic [30:0] iow_avg;
    logic        count_underflow;
  } out_item_t;

endpackage

// ----- design/twoa_div.sv -----
`timescale 1ns / 1ps
module twoa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [30:0] quot
);

  logic        run_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [63:0] rem_r;
  logic [64:0] sh;
  logic [64:0] diff;
  logic        ge;

  assign sh   = {rem_r, q_r[63]};
  assign diff = sh - {1'b0, divisor};
  assign ge   = sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(twoa_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[62:0], ge};
      rem_r <= ge ? diff[63:0] : sh[63:0];
    end
  end

  assign done = done_r;
  assign quot = (|q_r[63:31]) ? twoa_pkg::AVG_MAX : q_r[30:0];

endmodule

// ----- design/time_weighted_occupancy_averager_unit.sv -----
`timescale 1ns / 1ps
// Time-weighted task-count averager. Per-processor counts, interval starts and
// sums sit in one synchronous memory; each item is a read-modify-write of one
// entry (update) or a walk over all NUM_CPUS entries followed by three parallel
// 64-bit bit-serial divisions (query). Item length is set by the shared 32x32
// multiplier (six partial products per entry) and, for a query, the
// one-bit-per-cycle divider. Out-of-range updates and zero-interval queries
// answer in the cycle after they are taken. busy is high while an item is at
// work; results appear for one cycle on out_valid and cannot be stalled.
module time_weighted_occupancy_averager_unit #(
  parameter int NUM_CPUS    = twoa_pkg::NUM_CPUS_DEF,
  parameter int COUNT_WIDTH = twoa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  twoa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output twoa_pkg::out_item_t out_item
);

  localparam int CW = COUNT_WIDTH;
  localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int WW = 3 * CW + 4 * 64;
  localparam int SW = ((CW > 16) ? CW : 16) + 1;
  localparam logic [CW-1:0] CMAX = '1;

  twoa_pkg::state_t state_r, state_nxt;

  logic [WW-1:0]       mem [NUM_CPUS];
  logic [NUM_CPUS-1:0] vld_r;
  logic [WW-1:0]       rd_q_r;
  logic                rd_v_r;
  logic [AW-1:0]       ra;
  logic                we;
  logic [WW-1:0]       wd;

  twoa_pkg::in_item_t req_r, req_nxt;
  logic [CW-1:0] bigc_r, bigc_nxt, ioc_r, ioc_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic [63:0]   el_r, el_nxt;
  logic [63:0]   pp_r, pp_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [63:0]   acc_r [3];
  logic [63:0]   acc_nxt [3];
  logic [63:0]   tot_r [3];
  logic [63:0]   tot_nxt [3];
  logic [63:0]   span_r, span_nxt;
  logic [63:0]   lqt_r, lqt_nxt;
  logic          out_valid_r, out_valid_nxt;
  twoa_pkg::out_item_t out_item_r, out_item_nxt;
  logic          div_start;
  logic [2:0]    div_done;
  logic [30:0]   quot [3];
  logic [63:0]   dvd [3];

  logic [CW-1:0] w_run, w_big, w_io;
  logic [63:0]   w_start, w_rs, w_bs, w_is;
  logic [CW-1:0] in_big_c, in_io_c;
  logic          in_range;
  logic [63:0]   span_in;
  logic [31:0]   cnt32;
  logic [31:0]   el_half;
  logic [1:0]    cls;
  logic [SW-1:0] inc_sum;
  logic [CW-1:0] new_run;
  logic          uflow;

  assign {w_run, w_big, w_io, w_start, w_rs, w_bs, w_is} = word_r;

  assign in_big_c = (32'(in_item.big_count) > 32'(CMAX)) ? CMAX : CW'(in_item.big_count);
  assign in_io_c  = (32'(in_item.iowait_count) > 32'(CMAX)) ? CMAX : CW'(in_item.iowait_count);
  assign in_range = 32'(in_item.cpu_index) < 32'(NUM_CPUS);
  assign span_in  = in_item.timestamp - lqt_r;

  assign cls     = step_r[2:1];
  assign el_half = step_r[0] ? el_r[63:32] : el_r[31:0];
  always_comb begin
    unique case (cls)
      twoa_pkg::CLS_RUN: cnt32 = 32'(w_run);
      twoa_pkg::CLS_BIG: cnt32 = req_r.req_type ? 32'(w_big) : 32'(bigc_r);
      default:           cnt32 = req_r.req_type ? 32'(w_io) : 32'(ioc_r);
    endcase
  end
  assign pp_nxt = 64'(el_half) * 64'(cnt32);

  assign inc_sum = SW'(w_run) + SW'(req_r.count_delta);
  always_comb begin
    uflow   = 1'b0;
    new_run = w_run;
    if (req_r.is_increment) begin
      new_run = (inc_sum > SW'(CMAX)) ? CMAX : CW'(inc_sum);
    end else if (SW'(req_r.count_delta) > SW'(w_run)) begin
      new_run = '0;
      uflow   = 1'b1;
    end else begin
      new_run = CW'(SW'(w_run) - SW'(req_r.count_delta));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r] <= wd;
    end
    rd_q_r <= mem[ra];
    rd_v_r <= vld_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    bigc_nxt      = bigc_r;
    ioc_nxt       = ioc_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    el_nxt        = el_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    span_nxt      = span_r;
    lqt_nxt       = lqt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ra            = idx_r;
    we            = 1'b0;
    wd            = '0;
    div_start     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (tot_r[k] << 6) + (tot_r[k] << 5) + (tot_r[k] << 2);
    end
    unique case (state_r)
      twoa_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt      = in_item;
          bigc_nxt     = in_big_c;
          ioc_nxt      = in_io_c;
          span_nxt     = span_in;
          out_item_nxt = '0;
          for (int k = 0; k < 3; k++) begin
            tot_nxt[k] = '0;
          end
          if (in_item.req_type) begin
            out_item_nxt.is_query_result = 1'b1;
            idx_nxt = '0;
            ra      = '0;
            if (span_in == 64'd0) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = twoa_pkg::ST_ELAP;
            end
          end else begin
            idx_nxt = AW'(in_item.cpu_index);
            ra      = AW'(in_item.cpu_index);
            if (in_range) begin
              state_nxt = twoa_pkg::ST_ELAP;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      twoa_pkg::ST_ELAP: begin
        word_nxt  = rd_v_r ? rd_q_r : '0;
        el_nxt    = req_r.timestamp - (rd_v_r ? rd_q_r[4*64-1:3*64] : 64'd0);
        acc_nxt[0] = rd_v_r ? rd_q_r[3*64-1:2*64] : 64'd0;
        acc_nxt[1] = rd_v_r ? rd_q_r[2*64-1:64] : 64'd0;
        acc_nxt[2] = rd_v_r ? rd_q_r[63:0] : 64'd0;
        step_nxt  = '0;
        state_nxt = twoa_pkg::ST_MUL;
      end
      twoa_pkg::ST_MUL: begin
        state_nxt = twoa_pkg::ST_ACC;
      end
      twoa_pkg::ST_ACC: begin
        acc_nxt[cls] = acc_r[cls] + (step_r[0] ? {pp_r[31:0], 32'd0} : pp_r);
        step_nxt     = step_r + 3'd1;
        state_nxt    = (step_r == 3'd5) ? twoa_pkg::ST_WB : twoa_pkg::ST_MUL;
      end
      twoa_pkg::ST_WB: begin
        we = 1'b1;
        if (req_r.req_type) begin
          wd = {w_run, w_big, w_io, req_r.timestamp, 64'd0, 64'd0, 64'd0};
          for (int k = 0; k < 3; k++) begin
            tot_nxt[k] = tot_r[k] + acc_r[k];
          end
          if (32'(idx_r) == 32'(NUM_CPUS - 1)) begin
            state_nxt = twoa_pkg::ST_DIV;
            lqt_nxt   = req_r.timestamp;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            ra        = idx_r + AW'(1);
            state_nxt = twoa_pkg::ST_ELAP;
          end
        end else begin
          wd = {new_run, bigc_r, ioc_r, req_r.timestamp, acc_r[0], acc_r[1], acc_r[2]};
          out_item_nxt.count_underflow = uflow;
          out_valid_nxt = 1'b1;
          state_nxt     = twoa_pkg::ST_IDLE;
        end
        div_start = state_nxt == twoa_pkg::ST_DIV;
      end
      twoa_pkg::ST_DIV: begin
        if (div_done[0]) begin
          out_item_nxt.run_avg = quot[0];
          out_item_nxt.big_avg = quot[1];
          out_item_nxt.iow_avg = quot[2];
          out_valid_nxt = 1'b1;
          state_nxt     = twoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = twoa_pkg::ST_IDLE;
      end
    endcase
  end

  // divider inputs: tot_r is final in the cycle after write-back, start then
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      lqt_r       <= '0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lqt_r       <= lqt_nxt;
      div_go_r    <= div_start;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    bigc_r     <= bigc_nxt;
    ioc_r      <= ioc_nxt;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
    el_r       <= el_nxt;
    pp_r       <= pp_nxt;
    step_r     <= step_nxt;
    acc_r      <= acc_nxt;
    tot_r      <= tot_nxt;
    span_r     <= span_nxt;
    out_item_r <= out_item_nxt;
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    twoa_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_go_r),
      .dividend (dvd[g]),
      .divisor  (span_r),
      .done     (div_done[g]),
      .quot     (quot[g])
    );
  end

  assign busy      = state_r != twoa_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/twoa_checker.sv -----
`timescale 1ns / 1ps
module twoa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input twoa_pkg::out_item_t out_item,
  input logic                out_valid
);

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  a_upd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.is_query_result |->
      out_item.run_avg == 31'd0 && out_item.big_avg == 31'd0 &&
      out_item.iow_avg == 31'd0) else $error("update result carries averages");

  a_qry_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_query_result |-> !out_item.count_underflow)
    else $error("query result flags underflow");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("accepted item dropped");

endmodule

bind time_weighted_occupancy_averager_unit twoa_checker u_twoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_item  (out_item),
  .out_valid (out_valid)
);

// ----- bench/time_weighted_occupancy_averager_unit_tb.sv -----
`timescale 1ns / 1ps
module time_weighted_occupancy_averager_unit_tb;

  localparam int NCPU = 8;
  localparam logic [63:0] CNT_MAX = 64'd65535;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IN_W = $bits(twoa_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  twoa_pkg::in_item_t in_item = '0;
  logic out_valid;
  twoa_pkg::out_item_t out_item;

  time_weighted_occupancy_averager_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #4 clk = ~clk;

  logic [63:0] run_cnt [NCPU];
  logic [63:0] big_cnt [NCPU];
  logic [63:0] io_cnt [NCPU];
  logic [63:0] span_start [NCPU];
  logic [63:0] run_acc [NCPU];
  logic [63:0] big_acc [NCPU];
  logic [63:0] io_acc [NCPU];
  logic [63:0] prev_query;

  twoa_pkg::in_item_t pending_items[$];
  twoa_pkg::out_item_t expected_avgs[$];
  int error_count = 0;
  int idle_pct = 6;
  int stall_count = 0;
  bit stim_done = 1'b0;
  bit in_acc = 1'b0;
  logic [63:0] now_ts;

  function automatic logic [30:0] scaled_avg(logic [63:0] total, logic [63:0] span);
    logic [63:0] q;
    q = (total * 64'd100) / span;
    return (q > 64'd2147483647) ? 31'h7fff_ffff : q[30:0];
  endfunction

  function automatic twoa_pkg::out_item_t occupancy_step(twoa_pkg::in_item_t it);
    twoa_pkg::out_item_t r;
    logic [63:0] el, bg, io, dl, tr, tb, ti, span;
    r = '0;
    if (it.req_type == 1'b0) begin
      el = it.timestamp - span_start[it.cpu_index];
      bg = {48'd0, it.big_count};
      io = {48'd0, it.iowait_count};
      dl = {48'd0, it.count_delta};
      run_acc[it.cpu_index] += run_cnt[it.cpu_index] * el;
      big_acc[it.cpu_index] += bg * el;
      io_acc[it.cpu_index] += io * el;
      big_cnt[it.cpu_index] = bg;
      io_cnt[it.cpu_index] = io;
      span_start[it.cpu_index] = it.timestamp;
      if (it.is_increment) begin
        run_cnt[it.cpu_index] = (run_cnt[it.cpu_index] + dl > CNT_MAX) ?
                                CNT_MAX : run_cnt[it.cpu_index] + dl;
      end else if (dl > run_cnt[it.cpu_index]) begin
        run_cnt[it.cpu_index] = 64'd0;
        r.count_underflow = 1'b1;
      end else begin
        run_cnt[it.cpu_index] -= dl;
      end
    end else begin
      r.is_query_result = 1'b1;
      span = it.timestamp - prev_query;
      if (span != 64'd0) begin
        tr = 64'd0; tb = 64'd0; ti = 64'd0;
        for (int i = 0; i < NCPU; i++) begin
          el = it.timestamp - span_start[i];
          tr += run_acc[i] + run_cnt[i] * el;
          tb += big_acc[i] + big_cnt[i] * el;
          ti += io_acc[i] + io_cnt[i] * el;
          span_start[i] = it.timestamp;
          run_acc[i] = 64'd0; big_acc[i] = 64'd0; io_acc[i] = 64'd0;
        end
        prev_query = it.timestamp;
        r.run_avg = scaled_avg(tr, span);
        r.big_avg = scaled_avg(tb, span);
        r.iow_avg = scaled_avg(ti, span);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic twoa_pkg::in_item_t make_update(logic [2:0] c, logic [15:0] d, logic i,
                                                     logic [63:0] t, logic [15:0] b,
                                                     logic [15:0] w);
    twoa_pkg::in_item_t it;
    it = '0;
    it.cpu_index = c; it.count_delta = d; it.is_increment = i;
    it.timestamp = t; it.big_count = b; it.iowait_count = w;
    return it;
  endfunction

  function automatic twoa_pkg::in_item_t make_query(logic [63:0] t);
    twoa_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom});
    it.req_type = 1'b1;
    it.timestamp = t;
    return it;
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 8));
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // sample
  always @(posedge clk) begin
    in_acc <= rst_n && start && !busy;
  end

  // drive
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        expected_avgs.push_back(occupancy_step(in_item));
        void'(pending_items.pop_front());
      end
      if (in_acc || !start) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          start <= 1'b0;
          in_item <= IN_W'({$urandom, $urandom, $urandom, $urandom});
        end
      end
    end
  end

  // check
  always @(posedge clk) begin
    twoa_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_avgs.size() == 0) begin
        report_mismatch("unexpected item", 64'(out_item), 64'd0);
      end else begin
        want = expected_avgs.pop_front();
        if (out_item.is_query_result !== want.is_query_result)
          report_mismatch("is_query_result", 64'(out_item.is_query_result),
                          64'(want.is_query_result));
        if (out_item.run_avg !== want.run_avg)
          report_mismatch("run_avg", 64'(out_item.run_avg), 64'(want.run_avg));
        if (out_item.big_avg !== want.big_avg)
          report_mismatch("big_avg", 64'(out_item.big_avg), 64'(want.big_avg));
        if (out_item.iow_avg !== want.iow_avg)
          report_mismatch("iow_avg", 64'(out_item.iow_avg), 64'(want.iow_avg));
        if (out_item.count_underflow !== want.count_underflow)
          report_mismatch("count_underflow", 64'(out_item.count_underflow),
                          64'(want.count_underflow));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > WATCHDOG_LIMIT) begin
      $display("time_weighted_occupancy_averager_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] step;
    int q;
    for (int i = 0; i < NCPU; i++) begin
      run_cnt[i] = 64'd0; big_cnt[i] = 64'd0; io_cnt[i] = 64'd0;
      span_start[i] = 64'd0; run_acc[i] = 64'd0; big_acc[i] = 64'd0; io_acc[i] = 64'd0;
    end
    prev_query = 64'd0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    pending_items.push_back(make_query(64'd0));
    pending_items.push_back(make_update(3'd0, 16'd5, 1'b0, 64'd100, 16'd0, 16'd0));
    pending_items.push_back(make_update(3'd0, 16'hffff, 1'b1, 64'd200, 16'hffff, 16'hffff));
    pending_items.push_back(make_update(3'd0, 16'hffff, 1'b1, 64'd300, 16'd3, 16'd7));
    pending_items.push_back(make_update(3'd7, 16'd0, 1'b0, 64'd300, 16'd1, 16'd2));
    pending_items.push_back(make_query(64'd1000));
    pending_items.push_back(make_query(64'd1000));
    pending_items.push_back(make_update(3'd3, 16'd9, 1'b1, 64'd1003, 16'hffff, 16'd0));
    pending_items.push_back(make_query(64'd1004));
    pending_items.push_back(make_update(3'd3, 16'hffff, 1'b0, 64'd900, 16'd1, 16'd1));
    pending_items.push_back(make_query(64'd500));
    pending_items.push_back(make_update(3'd5, 16'd1, 1'b1, 64'hffff_ffff_ffff_fff0, 16'd4,
                                        16'd4));
    pending_items.push_back(make_query(64'hffff_ffff_ffff_ffff));
    pending_items.push_back(make_query(64'h0000_0000_0000_0010));
    pending_items.push_back(make_update(3'd2, 16'hffff, 1'b1, 64'h8000_0000_0000_0000,
                                        16'hffff, 16'hffff));
    pending_items.push_back(make_query(64'h8000_0000_0000_0001));
    pending_items.push_back(make_query(64'hffff_ffff_ffff_fffe));

    now_ts = 64'h1_0000_0000;
    for (int n = 0; n < 640; n++) begin
      if (n == 215) idle_pct = 51;
      if (n == 430) idle_pct = 0;
      q = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: step = {$urandom, $urandom};
        1: step = 64'd0;
        2: step = 64'($urandom_range(1, 4));
        default: step = 64'($urandom_range(1, 100000));
      endcase
      if ($urandom_range(0, 49) == 0) now_ts = now_ts - 64'($urandom_range(1, 1000));
      else now_ts = now_ts + step;
      if (q < 12)
        pending_items.push_back(make_query(now_ts));
      else
        pending_items.push_back(make_update(3'($urandom), rand_count(), 1'($urandom), now_ts,
                                            rand_count(), rand_count()));
      while (pending_items.size() > 4) @(negedge clk);
    end
    wait (pending_items.size() == 0 && expected_avgs.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("time_weighted_occupancy_averager_unit_tb: clean");
    end else begin
      $display("time_weighted_occupancy_averager_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- time_weighted_occupancy_averager_unit.f -----
design/twoa_pkg.sv
design/twoa_div.sv
design/time_weighted_occupancy_averager_unit.sv
design/twoa_checker.sv
bench/time_weighted_occupancy_averager_unit_tb.sv
